// File: hdl/hws_pkg.sv
// Shared types, codes and constants for the heartbeat watchdog supervisor.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package hws_pkg;

  // Default table size.
  localparam int CLIENT_SLOTS_DEF = 8;

  // Field widths.
  localparam int FUNC_W    = 3;
  localparam int ID_W      = 64;
  localparam int PID_W     = 22;
  localparam int MS_W      = 19;
  localparam int SIDX_W    = 3;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 3;
  localparam int ACTIVE_W  = 4;
  localparam int FEED_CNT_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  // Heartbeat limit range and age saturation value.
  localparam logic [MS_W-1:0] LIMIT_MIN_MS = MS_W'(5 * 1000);
  localparam logic [MS_W-1:0] LIMIT_MAX_MS = MS_W'(300 * 1000);
  localparam logic [MS_W-1:0] AGE_MAX      = '1;

  // Reset values of the configuration registers.
  localparam logic [FEED_CNT_W-1:0] FEED_INTERVAL_RST = FEED_CNT_W'(9000);
  localparam logic                  WATCHDOG_EN_RST   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FEED_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG_EN   = 1'd1;

  // Command function codes.
  localparam logic [FUNC_W-1:0] FN_REGISTER   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PING       = 3'd1;
  localparam logic [FUNC_W-1:0] FN_UNREGISTER = 3'd2;
  localparam logic [FUNC_W-1:0] FN_TICK       = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ       = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_TIMEOUT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_WRONG_PID   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NO_PERM     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_HALTED      = 3'd6;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK_RD,
    S_WALK_EV,
    S_TICK_END,
    S_READ_RD,
    S_READ_EV,
    S_DONE
  } state_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_STATUS,
    OP_TICK_SLOT,
    OP_TAKE_SLOT,
    OP_PING_SLOT,
    OP_FREE_SLOT,
    OP_TICK_END,
    OP_READ_OUT
  } dp_op_t;

  // Command bundle from controller to datapath.
  typedef struct packed {
    dp_op_t              op;
    logic [STATUS_W-1:0] code;
    logic                step;
    logic                rd_sidx;
  } dp_cmd_t;

  // Status bundle from datapath to controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              failed;
    logic              tmo_ok;
    logic              cur_active;
    logic              id_hit;
    logic              last;
  } dp_stat_t;

  // One slot of the client table as stored in memory.
  typedef struct packed {
    logic [ID_W-1:0]  ident;
    logic [PID_W-1:0] owner;
    logic [MS_W-1:0]  limit;
    logic [MS_W-1:0]  age;
    logic             own_check;
  } slot_word_t;

endpackage

// File: hdl/hws_ctrl.sv
// Sequencing state machine of the heartbeat watchdog supervisor.
// Depends on hws_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
`timescale 1ns / 1ps

module hws_ctrl import hws_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     done
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.func == FN_TICK) begin
          state_next = S_WALK_RD;
        end else if (stat.failed) begin
          state_next = S_DONE;
        end else begin
          case (stat.func)
            FN_REGISTER:   state_next = stat.tmo_ok ? S_WALK_RD : S_DONE;
            FN_PING:       state_next = S_WALK_RD;
            FN_UNREGISTER: state_next = S_WALK_RD;
            FN_READ:       state_next = S_READ_RD;
            default:       state_next = S_DONE;
          endcase
        end
      end
      S_WALK_RD: state_next = S_WALK_EV;
      S_WALK_EV: begin
        case (stat.func)
          FN_TICK: begin
            state_next = stat.last ? S_TICK_END : S_WALK_RD;
          end
          FN_REGISTER: begin
            state_next = (!stat.cur_active || stat.last) ? S_DONE : S_WALK_RD;
          end
          FN_PING, FN_UNREGISTER: begin
            state_next = (stat.id_hit || stat.last) ? S_DONE : S_WALK_RD;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_TICK_END: state_next = S_DONE;
      S_READ_RD:  state_next = S_READ_EV;
      S_READ_EV:  state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '{op: OP_NONE, code: ST_OK, step: 1'b0, rd_sidx: 1'b0};
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
        end
      end
      S_DECODE: begin
        if (stat.func != FN_TICK && stat.failed) begin
          cmd.op   = OP_STATUS;
          cmd.code = ST_HALTED;
        end else if (stat.func == FN_REGISTER && !stat.tmo_ok) begin
          cmd.op   = OP_STATUS;
          cmd.code = ST_BAD_TIMEOUT;
        end
      end
      S_WALK_EV: begin
        case (stat.func)
          FN_TICK: begin
            cmd.op   = OP_TICK_SLOT;
            cmd.step = !stat.last;
          end
          FN_REGISTER: begin
            if (!stat.cur_active) begin
              cmd.op = OP_TAKE_SLOT;
            end else if (stat.last) begin
              cmd.op   = OP_STATUS;
              cmd.code = ST_FULL;
            end else begin
              cmd.step = 1'b1;
            end
          end
          FN_PING, FN_UNREGISTER: begin
            if (stat.id_hit) begin
              cmd.op = (stat.func == FN_PING) ? OP_PING_SLOT : OP_FREE_SLOT;
            end else if (stat.last) begin
              cmd.op   = OP_STATUS;
              cmd.code = ST_UNKNOWN;
            end else begin
              cmd.step = 1'b1;
            end
          end
          default: cmd.op = OP_NONE;
        endcase
      end
      S_TICK_END: cmd.op = OP_TICK_END;
      S_READ_RD:  cmd.rd_sidx = 1'b1;
      S_READ_EV:  cmd.op = OP_READ_OUT;
      default:    cmd.op = OP_NONE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// File: hdl/hws_dp.sv
// Datapath of the heartbeat watchdog supervisor: client table memory, slot flags,
// feed counter, failure latch and result registers. Depends on hws_pkg.
`timescale 1ns / 1ps

module hws_dp import hws_pkg::*; #(
  parameter int CLIENT_SLOTS = CLIENT_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [FUNC_W-1:0]     func,
  input  logic [ID_W-1:0]       client_id,
  input  logic [PID_W-1:0]      caller_pid,
  input  logic                  caller_is_root,
  input  logic [MS_W-1:0]       hb_limit,
  input  logic                  ignore_pid,
  input  logic [SIDX_W-1:0]     slot_index,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic [STATUS_W-1:0]   status,
  output logic [SLOT_W-1:0]     slot,
  output logic                  feed,
  output logic                  failed,
  output logic [ACTIVE_W-1:0]   active_count,
  output logic                  entry_active,
  output logic [ID_W-1:0]       entry_id,
  output logic [PID_W-1:0]      entry_pid,
  output logic [MS_W-1:0]       entry_timeout,
  output logic                  entry_check_pid
);

  localparam int IW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int CW = $clog2(CLIENT_SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CLIENT_SLOTS - 1);

  // Captured command fields.
  logic [FUNC_W-1:0] func_q;
  logic [ID_W-1:0]   id_q;
  logic [PID_W-1:0]  pid_q;
  logic              root_q;
  logic [MS_W-1:0]   tmo_q;
  logic              ign_q;
  logic [SIDX_W-1:0] sidx_q;

  // Control state.
  logic [IW-1:0]           cnt;
  logic [CLIENT_SLOTS-1:0] in_use;
  logic [CW-1:0]           count;
  logic [FEED_CNT_W-1:0]   feed_cnt;
  logic                    latch;
  logic                    miss;
  logic [FEED_CNT_W-1:0]   feed_interval;
  logic                    wd_en;

  // Client table.
  slot_word_t mem [CLIENT_SLOTS];
  slot_word_t rd_q;
  slot_word_t wdata;
  logic       mem_we;
  logic [IW-1:0] raddr;

  // Derived conditions.
  logic [IW-1:0]         sidx_addr;
  logic                  sidx_ok;
  logic                  sidx_active;
  logic                  cur_active;
  logic                  owner_ok;
  logic                  perm_ok;
  logic [MS_W-1:0]       aged;
  logic                  aged_miss;
  logic [FEED_CNT_W-1:0] feed_inc;
  logic                  feed_wrap;
  logic                  feed_val;

  always_comb begin
    sidx_addr   = IW'(sidx_q);
    sidx_ok     = 32'(sidx_q) < CLIENT_SLOTS;
    sidx_active = sidx_ok && in_use[sidx_addr];
    cur_active  = in_use[cnt];
    owner_ok    = !rd_q.own_check || (rd_q.owner == pid_q);
    perm_ok     = root_q || (pid_q == '0);
    aged        = (rd_q.age < AGE_MAX) ? rd_q.age + MS_W'(1) : rd_q.age;
    aged_miss   = aged > rd_q.limit;
    feed_inc    = feed_cnt + FEED_CNT_W'(1);
    feed_wrap   = feed_inc >= feed_interval;
    feed_val    = feed_wrap && !(latch || miss) && wd_en;
  end

  // Status toward the controller.
  always_comb begin
    stat.func       = func_q;
    stat.failed     = latch;
    stat.tmo_ok     = (tmo_q >= LIMIT_MIN_MS) && (tmo_q <= LIMIT_MAX_MS);
    stat.cur_active = cur_active;
    stat.id_hit     = cur_active && (rd_q.ident == id_q);
    stat.last       = (cnt == LAST_IDX);
  end

  // Table write data for aging, taking and pinging a slot.
  always_comb begin
    mem_we = 1'b0;
    wdata  = rd_q;
    case (cmd.op)
      OP_TICK_SLOT: begin
        mem_we    = cur_active;
        wdata.age = aged;
      end
      OP_TAKE_SLOT: begin
        mem_we = 1'b1;
        wdata  = '{ident: id_q, owner: pid_q, limit: tmo_q, age: '0,
                   own_check: !ign_q};
      end
      OP_PING_SLOT: begin
        mem_we    = owner_ok;
        wdata.age = '0;
      end
      default: mem_we = 1'b0;
    endcase
    raddr = cmd.rd_sidx ? sidx_addr : cnt;
  end

  // Table memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // Capture of the command fields on transfer.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      func_q <= func;
      id_q   <= client_id;
      pid_q  <= caller_pid;
      root_q <= caller_is_root;
      tmo_q  <= hb_limit;
      ign_q  <= ignore_pid;
      sidx_q <= slot_index;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      feed_interval <= FEED_INTERVAL_RST;
      wd_en         <= WATCHDOG_EN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FEED_INTERVAL: feed_interval <= cfg_data;
        CFG_WATCHDOG_EN:   wd_en <= cfg_data[0];
        default:           wd_en <= wd_en;
      endcase
    end
  end

  // Walk index, slot flags, active count, failure latch and feed counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      in_use   <= '0;
      count    <= '0;
      feed_cnt <= '0;
      latch    <= 1'b0;
      miss     <= 1'b0;
    end else begin
      if (cmd.step) begin
        cnt <= cnt + IW'(1);
      end
      case (cmd.op)
        OP_LOAD: begin
          cnt  <= '0;
          miss <= 1'b0;
        end
        OP_TICK_SLOT: begin
          if (cur_active && aged_miss) begin
            miss <= 1'b1;
          end
        end
        OP_TAKE_SLOT: begin
          in_use[cnt] <= 1'b1;
          count       <= count + CW'(1);
        end
        OP_FREE_SLOT: begin
          if (owner_ok || root_q) begin
            in_use[cnt] <= 1'b0;
            count       <= count - CW'(1);
          end
        end
        OP_TICK_END: begin
          latch    <= latch || miss;
          feed_cnt <= feed_wrap ? '0 : feed_inc;
        end
        default: latch <= latch;
      endcase
    end
  end

  // Result registers, cleared when a command is taken.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        status          <= ST_OK;
        slot            <= '0;
        feed            <= 1'b0;
        entry_active    <= 1'b0;
        entry_id        <= '0;
        entry_pid       <= '0;
        entry_timeout   <= '0;
        entry_check_pid <= 1'b0;
      end
      OP_STATUS: status <= cmd.code;
      OP_TAKE_SLOT: slot <= SLOT_W'(cnt);
      OP_PING_SLOT: begin
        slot <= SLOT_W'(cnt);
        if (!owner_ok) begin
          status <= ST_WRONG_PID;
        end
      end
      OP_FREE_SLOT: begin
        slot <= SLOT_W'(cnt);
        if (!(owner_ok || root_q)) begin
          status <= ST_WRONG_PID;
        end
      end
      OP_TICK_END: feed <= feed_val;
      OP_READ_OUT: begin
        slot <= sidx_q;
        if (!perm_ok) begin
          status <= ST_NO_PERM;
        end else if (sidx_active) begin
          entry_active    <= 1'b1;
          entry_id        <= rd_q.ident;
          entry_pid       <= rd_q.owner;
          entry_timeout   <= rd_q.limit;
          entry_check_pid <= rd_q.own_check;
        end
      end
      default: feed <= feed;
    endcase
  end

  assign failed       = latch;
  assign active_count = ACTIVE_W'(count);

endmodule

// File: hdl/heartbeat_watchdog_supervisor_top.sv
// Heartbeat watchdog supervisor top: one command per start, one result per done strobe.
// Refused or bad-timeout commands end after decode, and a read reads one table entry;
// register/ping/unregister walk k slots from slot 0 (k <= CLIENT_SLOTS), tick walks every
// slot and then S_TICK_END; the walk reads each entry in S_WALK_RD and evaluates it in S_WALK_EV.
// busy drops in the cycle after done, so the next command may start then; results cannot stall.
// Synchronous active-high rst frees every slot, clears the failure latch and feed counter.
`timescale 1ns / 1ps

module heartbeat_watchdog_supervisor_top import hws_pkg::*; #(
  parameter int CLIENT_SLOTS = CLIENT_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  start,
  output logic                  busy,
  output logic                  done,
  input  logic [FUNC_W-1:0]     func,
  input  logic [ID_W-1:0]       client_id,
  input  logic [PID_W-1:0]      caller_pid,
  input  logic                  caller_is_root,
  input  logic [MS_W-1:0]       hb_limit,
  input  logic                  ignore_pid,
  input  logic [SIDX_W-1:0]     slot_index,
  output logic [STATUS_W-1:0]   status,
  output logic [SLOT_W-1:0]     slot,
  output logic                  feed,
  output logic                  failed,
  output logic [ACTIVE_W-1:0]   active_count,
  output logic                  entry_active,
  output logic [ID_W-1:0]       entry_id,
  output logic [PID_W-1:0]      entry_pid,
  output logic [MS_W-1:0]       entry_timeout,
  output logic                  entry_check_pid
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  hws_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Table and result datapath.
  hws_dp #(
    .CLIENT_SLOTS (CLIENT_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .func            (func),
    .client_id       (client_id),
    .caller_pid      (caller_pid),
    .caller_is_root  (caller_is_root),
    .hb_limit        (hb_limit),
    .ignore_pid      (ignore_pid),
    .slot_index      (slot_index),
    .cmd             (cmd),
    .stat            (stat),
    .status          (status),
    .slot            (slot),
    .feed            (feed),
    .failed          (failed),
    .active_count    (active_count),
    .entry_active    (entry_active),
    .entry_id        (entry_id),
    .entry_pid       (entry_pid),
    .entry_timeout   (entry_timeout),
    .entry_check_pid (entry_check_pid)
  );

  // A feed pulse only comes from a tick and never once the block has failed.
  a_feed_ok: assert property (@(posedge clk) disable iff (rst)
    done && feed |-> !failed && stat.func == FN_TICK)
    else $error("feed pulse on a failed block or a non-tick command");

  // The failure latch holds until reset.
  a_latch_sticks: assert property (@(posedge clk) disable iff (rst)
    failed |=> failed)
    else $error("failure latch cleared without reset");

  // A halted status is only reported while failed.
  a_halted: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_HALTED |-> failed)
    else $error("halted status while not failed");

  // The active count never exceeds the table size.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(active_count) <= CLIENT_SLOTS)
    else $error("active count beyond table size");

endmodule

// File: tb/sv/tb.sv
// Self-checking bench for heartbeat_watchdog_supervisor_top: directed rows, random traffic,
// then a long tick run into the failure latch and the commands after it. Each result is checked against a predictor.
// Depends on hws_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb;
  import hws_pkg::*;

  localparam int SLOTS = CLIENT_SLOTS_DEF;
  localparam longint CYCLE_LIMIT = 1_000_000;
  localparam logic [FUNC_W-1:0] FN_SPARE = 3'd7;
  localparam logic [PID_W-1:0] PID_MAX = '1;

  localparam logic [ID_W-1:0] ID_A = '1;
  localparam logic [ID_W-1:0] ID_B = '0;
  localparam logic [ID_W-1:0] ID_C = 64'h0123_4567_89AB_CDEF;
  localparam logic [ID_W-1:0] ID_D = 64'h8000_0000_0000_0001;
  localparam logic [ID_W-1:0] ID_E = 64'h5A5A_A5A5_0F0F_F0F0;
  localparam logic [ID_W-1:0] ID_F = 64'h7FFF_0000_FFFF_0002;
  localparam logic [ID_W-1:0] ID_G = 64'h0000_0001_0000_0000;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   id;
    logic [PID_W-1:0]  pid;
    logic              root;
    logic [MS_W-1:0]   tmo;
    logic              ign;
    logic [SIDX_W-1:0] sidx;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                feed;
    logic                failed;
    logic [ACTIVE_W-1:0] active;
    logic                e_active;
    logic [ID_W-1:0]     e_id;
    logic [PID_W-1:0]    e_pid;
    logic [MS_W-1:0]     e_tmo;
    logic                e_chk;
  } reply_t;

  typedef struct {
    cmd_t                cmd;
    bit                  known;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [ACTIVE_W-1:0] active;
  } row_t;

  // Block ports.
  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  start;
  logic                  busy;
  logic                  done;
  logic [FUNC_W-1:0]     func;
  logic [ID_W-1:0]       client_id;
  logic [PID_W-1:0]      caller_pid;
  logic                  caller_is_root;
  logic [MS_W-1:0]       hb_limit;
  logic                  ignore_pid;
  logic [SIDX_W-1:0]     slot_index;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_W-1:0]     slot;
  logic                  feed;
  logic                  failed;
  logic [ACTIVE_W-1:0]   active_count;
  logic                  entry_active;
  logic [ID_W-1:0]       entry_id;
  logic [PID_W-1:0]      entry_pid;
  logic [MS_W-1:0]       entry_timeout;
  logic                  entry_check_pid;

  // Predicted client table, feed counter, failure latch and registers.
  logic                  tbl_used  [SLOTS];
  logic [ID_W-1:0]       tbl_ident [SLOTS];
  logic [PID_W-1:0]      tbl_owner [SLOTS];
  logic [MS_W-1:0]       tbl_limit [SLOTS];
  logic [MS_W-1:0]       tbl_age   [SLOTS];
  logic                  tbl_check [SLOTS];
  logic [FEED_CNT_W-1:0] feed_cnt;
  logic                  halted;
  logic [FEED_CNT_W-1:0] cfg_interval;
  logic                  cfg_wd_en;

  reply_t replies_due [$];
  row_t   directed [$];
  reply_t due;
  int     mismatches;
  longint cycles;
  bit     calm;

  logic [ID_W-1:0]  id_pool  [8];
  logic [PID_W-1:0] pid_pool [6];
  int unsigned phase_interval [5] = '{0, 3, 59000, 6272, 5};
  bit          phase_enable   [5] = '{1, 0, 1, 1, 1};

  heartbeat_watchdog_supervisor_top i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int live_slots();
    int n;
    int i;
    n = 0;
    for (i = 0; i < SLOTS; i++) if (tbl_used[i]) n++;
    return n;
  endfunction

  // Applies one command to the predicted state and returns the result it must produce.
  function automatic reply_t predict_reply(cmd_t c);
    reply_t r;
    int     i;
    int     hit;
    logic   missed;
    logic   taken;
    logic   owner_ok;
    r = '0;
    hit = -1;
    missed = 1'b0;
    taken = 1'b0;
    if (c.func == FN_TICK) begin
      for (i = 0; i < SLOTS; i++) begin
        if (tbl_used[i]) begin
          if (tbl_age[i] != AGE_MAX) tbl_age[i] = tbl_age[i] + 1'b1;
          if (tbl_age[i] > tbl_limit[i]) missed = 1'b1;
        end
      end
      if (missed) halted = 1'b1;
      feed_cnt = feed_cnt + 1'b1;
      if (feed_cnt >= cfg_interval) begin
        feed_cnt = '0;
        r.feed = !halted && cfg_wd_en;
      end
    end else if (halted) begin
      r.status = ST_HALTED;
    end else begin
      case (c.func)
        FN_REGISTER: begin
          if (c.tmo < LIMIT_MIN_MS || c.tmo > LIMIT_MAX_MS) begin
            r.status = ST_BAD_TIMEOUT;
          end else begin
            // Lowest free slot wins.
            for (i = 0; i < SLOTS; i++) begin
              if (!taken && !tbl_used[i]) begin
                tbl_used[i] = 1'b1;
                tbl_ident[i] = c.id;
                tbl_owner[i] = c.pid;
                tbl_limit[i] = c.tmo;
                tbl_age[i] = '0;
                tbl_check[i] = !c.ign;
                r.slot = SLOT_W'(i);
                taken = 1'b1;
              end
            end
            r.status = taken ? ST_OK : ST_FULL;
          end
        end
        FN_PING, FN_UNREGISTER: begin
          for (i = 0; i < SLOTS; i++)
            if (hit < 0 && tbl_used[i] && tbl_ident[i] == c.id) hit = i;
          if (hit < 0) begin
            r.status = ST_UNKNOWN;
          end else begin
            owner_ok = !tbl_check[hit] || tbl_owner[hit] == c.pid;
            r.slot = SLOT_W'(hit);
            if (c.func == FN_PING) begin
              if (owner_ok) tbl_age[hit] = '0;
              else r.status = ST_WRONG_PID;
            end else begin
              if (owner_ok || c.root) tbl_used[hit] = 1'b0;
              else r.status = ST_WRONG_PID;
            end
          end
        end
        FN_READ: begin
          r.slot = c.sidx;
          if (!c.root && c.pid != '0) begin
            r.status = ST_NO_PERM;
          end else if (int'(c.sidx) < SLOTS && tbl_used[c.sidx]) begin
            r.e_active = 1'b1;
            r.e_id = tbl_ident[c.sidx];
            r.e_pid = tbl_owner[c.sidx];
            r.e_tmo = tbl_limit[c.sidx];
            r.e_chk = tbl_check[c.sidx];
          end
        end
        default: ;
      endcase
    end
    r.failed = halted;
    r.active = ACTIVE_W'(live_slots());
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                    logic [PID_W-1:0] pid, logic root, logic [MS_W-1:0] tmo,
                                    logic ign, logic [SIDX_W-1:0] sidx);
    cmd_t c;
    c.func = f;
    c.id = id;
    c.pid = pid;
    c.root = root;
    c.tmo = tmo;
    c.ign = ign;
    c.sidx = sidx;
    return c;
  endfunction

  function automatic row_t row(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                               logic [PID_W-1:0] pid, logic root, logic [MS_W-1:0] tmo,
                               logic ign, logic [SIDX_W-1:0] sidx, bit known,
                               logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] sl,
                               logic [ACTIVE_W-1:0] act);
    row_t r;
    r.cmd = make_cmd(f, id, pid, root, tmo, ign, sidx);
    r.known = known;
    r.status = st;
    r.slot = sl;
    r.active = act;
    return r;
  endfunction

  // Mostly well-formed traffic: pings and unregisters usually target a live client,
  // usually from its owner. All fields carry random bits whether used or not.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   p;
    int   k;
    int   cnt;
    int   i;
    c.id = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : id_pool[$urandom_range(0, 7)];
    c.pid = ($urandom_range(0, 3) == 0) ? PID_W'($urandom) : pid_pool[$urandom_range(0, 5)];
    c.root = ($urandom_range(0, 3) == 0);
    c.tmo = MS_W'($urandom);
    c.ign = 1'($urandom_range(0, 1));
    c.sidx = SIDX_W'($urandom);
    p = $urandom_range(0, 99);
    if (p < 22) c.func = FN_REGISTER;
    else if (p < 42) c.func = FN_PING;
    else if (p < 60) c.func = FN_UNREGISTER;
    else if (p < 78) c.func = FN_TICK;
    else if (p < 95) c.func = FN_READ;
    else c.func = FUNC_W'($urandom_range(int'(FN_READ) + 1, (1 << FUNC_W) - 1));
    if (c.func == FN_REGISTER) begin
      p = $urandom_range(0, 99);
      if (p < 80) c.tmo = MS_W'($urandom_range(int'(LIMIT_MIN_MS), int'(LIMIT_MAX_MS)));
      else if (p < 85) c.tmo = LIMIT_MIN_MS;
      else if (p < 90) c.tmo = LIMIT_MAX_MS;
    end
    if ((c.func == FN_PING || c.func == FN_UNREGISTER) && live_slots() > 0 &&
        $urandom_range(0, 9) < 7) begin
      k = $urandom_range(0, live_slots() - 1);
      cnt = 0;
      for (i = 0; i < SLOTS; i++) begin
        if (tbl_used[i]) begin
          if (cnt == k) begin
            c.id = tbl_ident[i];
            if ($urandom_range(0, 9) < 7) c.pid = tbl_owner[i];
          end
          cnt++;
        end
      end
    end
    return c;
  endfunction

  // Mostly short gaps, a few long ones, none during a calm stretch.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Presents one command and waits for its transfer; returns the predicted result.
  task automatic transfer(input cmd_t c, input int gap, output reply_t want);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    func <= c.func;
    client_id <= c.id;
    caller_pid <= c.pid;
    caller_is_root <= c.root;
    hb_limit <= c.tmo;
    ignore_pid <= c.ign;
    slot_index <= c.sidx;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = predict_reply(c);
  endtask

  task automatic issue(input cmd_t c, input int gap);
    reply_t want;
    transfer(c, gap, want);
    replies_due.push_back(want);
  endtask

  // Drops start and waits until every expected result has come back.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == CFG_FEED_INTERVAL) cfg_interval = data;
    else cfg_wd_en = data[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Each done strobe is one result transfer, matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (replies_due.size() == 0) begin
        $error("result with no command outstanding");
        mismatches++;
      end else begin
        due = replies_due.pop_front();
        compare_field("status", due.status, status);
        compare_field("slot", due.slot, slot);
        compare_field("feed", due.feed, feed);
        compare_field("failed", due.failed, failed);
        compare_field("active_count", due.active, active_count);
        compare_field("entry_active", due.e_active, entry_active);
        compare_field("entry_id", due.e_id, entry_id);
        compare_field("entry_pid", due.e_pid, entry_pid);
        compare_field("entry_timeout", due.e_tmo, entry_timeout);
        compare_field("entry_check_pid", due.e_chk, entry_check_pid);
      end
    end
  end

  // Hard stop in case the handshake hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("heartbeat_watchdog_supervisor_top regression: fail");
      $finish;
    end
  end

  initial begin
    reply_t      want;
    logic [CFG_DATA_W-1:0] word;
    int          ph;
    int          n;
    int          i;
    int          sel;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    start = 1'b0;
    func = '0;
    client_id = '0;
    caller_pid = '0;
    caller_is_root = 1'b0;
    hb_limit = '0;
    ignore_pid = 1'b0;
    slot_index = '0;
    mismatches = 0;
    cycles = 0;
    calm = 1'b0;

    for (i = 0; i < SLOTS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_ident[i] = '0;
      tbl_owner[i] = '0;
      tbl_limit[i] = '0;
      tbl_age[i] = '0;
      tbl_check[i] = 1'b0;
    end
    feed_cnt = '0;
    halted = 1'b0;
    cfg_interval = FEED_INTERVAL_RST;
    cfg_wd_en = WATCHDOG_EN_RST;

    id_pool = '{ID_A, ID_B, ID_C, ID_D, ID_E, ID_F, ID_G, {$urandom, $urandom}};
    pid_pool = '{'0, PID_MAX, 22'd77, 22'd1234, 22'd3, PID_W'($urandom)};

    // Directed rows: func, id, pid, root, timeout, ignore, index | known status, slot, count.
    // Every slot is written before the first readout.
    directed.push_back(row(FN_TICK,       ID_B, '0,      0, '0,           0, 0,
                           1, ST_OK, 0, 0));
    directed.push_back(row(FN_PING,       ID_B, '0,      0, '0,           0, 0,
                           1, ST_UNKNOWN, 0, 0));
    directed.push_back(row(FN_UNREGISTER, ID_A, PID_MAX, 1, '0,           0, 0,
                           1, ST_UNKNOWN, 0, 0));
    directed.push_back(row(FN_REGISTER,   ID_A, '0,      0, LIMIT_MIN_MS - 1'b1, 0, 0,
                           1, ST_BAD_TIMEOUT, 0, 0));
    directed.push_back(row(FN_REGISTER,   ID_A, '0,      0, LIMIT_MAX_MS + 1'b1, 0, 0,
                           1, ST_BAD_TIMEOUT, 0, 0));
    directed.push_back(row(FN_REGISTER,   ID_A, '0,      0, AGE_MAX,      0, 0,
                           1, ST_BAD_TIMEOUT, 0, 0));
    directed.push_back(row(FN_SPARE,      ID_A, PID_MAX, 1, AGE_MAX,      1, 7,
                           1, ST_OK, 0, 0));
    directed.push_back(row(FN_REGISTER,   ID_A, PID_MAX, 0, LIMIT_MIN_MS, 0, 0,
                           1, ST_OK, 0, 1));
    directed.push_back(row(FN_REGISTER,   ID_B, '0,      0, LIMIT_MAX_MS, 1, 0,
                           1, ST_OK, 1, 2));
    // Same identifier twice: later lookups must pick the lower slot.
    directed.push_back(row(FN_REGISTER,   ID_A, 22'd77,  0, 19'd12345,    0, 0,
                           1, ST_OK, 2, 3));
    directed.push_back(row(FN_REGISTER,   ID_C, 22'd1234, 0, 19'd60000,   0, 0,
                           1, ST_OK, 3, 4));
    directed.push_back(row(FN_REGISTER,   ID_D, 22'h200000, 1, 19'd267144, 1, 0,
                           1, ST_OK, 4, 5));
    directed.push_back(row(FN_REGISTER,   ID_E, 22'd3,   0, 19'd100000,   0, 0,
                           1, ST_OK, 5, 6));
    directed.push_back(row(FN_REGISTER,   ID_F, 22'd9,   0, 19'd7000,     0, 0,
                           1, ST_OK, 6, 7));
    directed.push_back(row(FN_REGISTER,   ID_G, 22'd11,  0, 19'd8000,     0, 0,
                           1, ST_OK, 7, 8));
    directed.push_back(row(FN_REGISTER,   ID_C, 22'd1,   0, 19'd9999,     0, 0,
                           1, ST_FULL, 0, 8));
    directed.push_back(row(FN_READ,       ID_B, 22'd99,  1, '0,           0, 0,
                           0, ST_OK, 0, 0));
    directed.push_back(row(FN_READ,       ID_B, 22'd5,   0, '0,           0, 7,
                           1, ST_NO_PERM, 7, 8));
    directed.push_back(row(FN_READ,       ID_B, '0,      0, '0,           0, 1,
                           0, ST_OK, 0, 0));
    directed.push_back(row(FN_PING,       ID_A, 22'd5,   0, '0,           0, 0,
                           1, ST_WRONG_PID, 0, 8));
    directed.push_back(row(FN_PING,       ID_B, 22'd5,   0, '0,           0, 0,
                           1, ST_OK, 1, 8));
    directed.push_back(row(FN_UNREGISTER, ID_A, 22'd5,   0, '0,           0, 0,
                           1, ST_WRONG_PID, 0, 8));
    directed.push_back(row(FN_UNREGISTER, ID_A, 22'd5,   1, '0,           0, 0,
                           1, ST_OK, 0, 7));
    directed.push_back(row(FN_PING,       ID_A, 22'd77,  0, '0,           0, 0,
                           1, ST_OK, 2, 7));
    directed.push_back(row(FN_READ,       ID_B, '0,      1, '0,           0, 0,
                           0, ST_OK, 0, 0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[n]) begin
      transfer(directed[n].cmd, pick_gap(), want);
      if (directed[n].known) begin
        want.status = directed[n].status;
        want.slot = directed[n].slot;
        want.active = directed[n].active;
      end
      replies_due.push_back(want);
    end

    // Random traffic, one setting of both registers per phase; ages stay far below any limit.
    for (ph = 0; ph < 5; ph++) begin
      settle();
      write_reg(CFG_FEED_INTERVAL, CFG_DATA_W'(phase_interval[ph]));
      word = CFG_DATA_W'($urandom);
      word[0] = phase_enable[ph];
      write_reg(CFG_WATCHDOG_EN, word);
      for (n = 0; n < 150; n++) begin
        if (n % 25 == 0) calm = ($urandom_range(0, 3) == 0);
        issue(random_cmd(), pick_gap());
      end
    end
    calm = 1'b0;

    // Empty the table, then let a client at the shortest limit starve.
    settle();
    write_reg(CFG_FEED_INTERVAL, FEED_INTERVAL_RST);
    write_reg(CFG_WATCHDOG_EN, CFG_DATA_W'(WATCHDOG_EN_RST));
    while (live_slots() > 0) begin
      sel = -1;
      for (i = SLOTS - 1; i >= 0; i--) if (tbl_used[i]) sel = i;
      issue(make_cmd(FN_UNREGISTER, tbl_ident[sel], PID_W'($urandom), 1'b1, '0, 1'b0, '0),
            pick_gap());
    end
    issue(make_cmd(FN_REGISTER, ID_C, 22'd1234, 1'b0, LIMIT_MIN_MS, 1'b0, '0), pick_gap());
    issue(make_cmd(FN_REGISTER, ID_D, 22'd5, 1'b0, LIMIT_MAX_MS, 1'b1, '0), pick_gap());
    while (!halted) issue(make_cmd(FN_TICK, ID_B, '0, 1'b0, '0, 1'b0, '0), 0);

    // Once failed, every command but a tick is refused and ticks never feed.
    issue(make_cmd(FN_REGISTER, ID_E, 22'd3, 1'b0, LIMIT_MAX_MS, 1'b0, '0), pick_gap());
    issue(make_cmd(FN_PING, ID_C, 22'd1234, 1'b0, '0, 1'b0, '0), pick_gap());
    issue(make_cmd(FN_UNREGISTER, ID_D, 22'd5, 1'b1, '0, 1'b0, '0), pick_gap());
    issue(make_cmd(FN_READ, ID_B, '0, 1'b1, '0, 1'b0, 3'd0), pick_gap());
    issue(make_cmd(FN_SPARE, ID_B, '0, 1'b1, '0, 1'b0, '0), pick_gap());
    repeat (3) issue(make_cmd(FN_TICK, ID_B, '0, 1'b0, '0, 1'b0, '0), pick_gap());
    settle();
    write_reg(CFG_FEED_INTERVAL, '0);
    word = CFG_DATA_W'($urandom);
    word[0] = 1'b1;
    write_reg(CFG_WATCHDOG_EN, word);
    repeat (5) issue(make_cmd(FN_TICK, ID_B, '0, 1'b0, '0, 1'b0, '0), pick_gap());

    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("heartbeat_watchdog_supervisor_top regression: pass");
    end else begin
      $display("heartbeat_watchdog_supervisor_top regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/hws_pkg.sv
hdl/hws_ctrl.sv
hdl/hws_dp.sv
hdl/heartbeat_watchdog_supervisor_top.sv
tb/sv/tb.sv
